// ===== design/mlsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsc_pkg
// Shared types and constants of the lighting state converter.
// ----------------------------------------------------------------------------
package mlsc_pkg;

   localparam int FIELD_WIDTH     = 16;
   localparam int OPCODE_WIDTH    = 3;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef logic [OPCODE_WIDTH-1:0]    opcode_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam opcode_type OP_ACTUAL_TO_LINEAR = 3'd0;
   localparam opcode_type OP_LINEAR_TO_ACTUAL = 3'd1;
   localparam opcode_type OP_TEMP_TO_LEVEL    = 3'd2;
   localparam opcode_type OP_LEVEL_TO_TEMP    = 3'd3;
   localparam opcode_type OP_UNSIGNED_TO_LVL  = 3'd4;
   localparam opcode_type OP_LVL_TO_UNSIGNED  = 3'd5;

   localparam csr_index_type CSR_TEMP_MIN = 2'd0;
   localparam csr_index_type CSR_TEMP_MAX = 2'd1;

   localparam logic [FIELD_WIDTH-1:0] TEMP_MIN_RESET = 16'd800;
   localparam logic [FIELD_WIDTH-1:0] TEMP_MAX_RESET = 16'd20000;

   // Control that travels alongside every word through the pipeline.
   typedef struct packed {
      logic       valid;
      logic       err;
      logic       is_sqrt;
      opcode_type opcode;
   } cell_ctrl_type;

endpackage

// ===== design/mlsc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsc_req_if
// Request channel: opcode and operand with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mlsc_req_if;
   logic                                valid;
   logic                                ready;
   mlsc_pkg::opcode_type                opcode;
   logic [mlsc_pkg::FIELD_WIDTH-1:0]    operand;

   modport source (output valid, output opcode, output operand, input ready);
   modport sink   (input valid, input opcode, input operand, output ready);
endinterface

// ===== design/mlsc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsc_rsp_if
// Response channel: converted state and range error flag.
// ----------------------------------------------------------------------------
interface mlsc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mlsc_pkg::FIELD_WIDTH-1:0]    converted;
   logic                                range_error;

   modport source (output valid, output converted, output range_error, input ready);
   modport sink   (input valid, input converted, input range_error, output ready);
endinterface

// ===== design/mlsc_csr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsc_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mlsc_csr_if;
   logic                                valid;
   logic                                ready;
   mlsc_pkg::csr_index_type             index;
   logic [mlsc_pkg::FIELD_WIDTH-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/mesh_light_state_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_light_state_converter_top
// Lighting state converter: lightness actual/linear, colour temperature and
// hue/saturation to and from a signed level.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word carried
//  req_chan  in         opcode, operand
//  rsp_chan  out        converted, range_error
//  csr_chan  in         index (0 minimum, 1 maximum temperature), data
//
// A word is accepted in every cycle in which the response register is empty
// or being emptied; the pipeline holds one word per stage.
// A word passes through two preparation stages, one cell per result bit in
// the division/square-root chain, and the response register.
// Reset is synchronous and clears the valid bits and the temperature range
// to 800 K .. 20000 K. Register writes are always accepted.
// A stall on the response side freezes the whole pipeline at once.
// ----------------------------------------------------------------------------
module mesh_light_state_converter_top #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   mlsc_req_if.sink    req_chan,
   mlsc_rsp_if.source  rsp_chan,
   mlsc_csr_if.sink    csr_chan
);

   localparam int W = VALUE_WIDTH;
   localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

   logic [mlsc_pkg::FIELD_WIDTH-1:0] temp_min_ff, temp_max_ff;
   logic [mlsc_pkg::FIELD_WIDTH-1:0] converted_in, converted_ff;
   logic                             range_error_in, range_error_ff;
   logic                             rsp_valid_ff;
   logic                             en;
   logic [W-1:0]                     result;

   // One entry per boundary between cells; entry 0 is fed by the preparation
   // stages and entry W by the last cell.
   mlsc_pkg::cell_ctrl_type ctrl_chain [0:W];
   logic [W+1:0]            rem_chain  [0:W];
   logic [2*W-1:0]          num_chain  [0:W];
   logic [W-1:0]            root_chain [0:W];
   logic [W-1:0]            div_chain  [0:W];
   logic [W-1:0]            aux_chain  [0:W];
   logic [W:0]              valid_vec;

   // The pipeline advances whenever the response register can take a word.
   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_min_ff <= mlsc_pkg::TEMP_MIN_RESET;
         temp_max_ff <= mlsc_pkg::TEMP_MAX_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == mlsc_pkg::CSR_TEMP_MIN) begin
            temp_min_ff <= csr_chan.data;
         end
         if (csr_chan.index == mlsc_pkg::CSR_TEMP_MAX) begin
            temp_max_ff <= csr_chan.data;
         end
      end
   end

   mlsc_pre #(.W(W)) u_pre (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_chan.valid),
      .opcode      (req_chan.opcode),
      .operand     (req_chan.operand[W-1:0]),
      .lo          (temp_min_ff[W-1:0]),
      .hi          (temp_max_ff[W-1:0]),
      .ctrl_out    (ctrl_chain[0]),
      .rem_out     (rem_chain[0]),
      .num_out     (num_chain[0]),
      .root_out    (root_chain[0]),
      .divisor_out (div_chain[0]),
      .aux_out     (aux_chain[0])
   );

   for (genvar i = 0; i < W; i++) begin : g_cell
      mlsc_cell #(.W(W)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .en          (en),
         .ctrl_in     (ctrl_chain[i]),
         .rem_in      (rem_chain[i]),
         .num_in      (num_chain[i]),
         .root_in     (root_chain[i]),
         .divisor_in  (div_chain[i]),
         .aux_in      (aux_chain[i]),
         .ctrl_out    (ctrl_chain[i+1]),
         .rem_out     (rem_chain[i+1]),
         .num_out     (num_chain[i+1]),
         .root_out    (root_chain[i+1]),
         .divisor_out (div_chain[i+1]),
         .aux_out     (aux_chain[i+1])
      );
   end

   for (genvar i = 0; i <= W; i++) begin : g_valid
      assign valid_vec[i] = ctrl_chain[i].valid;
   end

   // Final correction: the level offset for temperature to level, the range
   // minimum for level to temperature; the offset hue/saturation value rides
   // along in the auxiliary lane. An empty or inverted range forces a zero result.
   always_comb begin
      unique case (ctrl_chain[W].opcode)
         mlsc_pkg::OP_ACTUAL_TO_LINEAR, mlsc_pkg::OP_LINEAR_TO_ACTUAL: begin
            result = root_chain[W];
         end
         mlsc_pkg::OP_TEMP_TO_LEVEL: begin
            result = root_chain[W] - HALF;
         end
         mlsc_pkg::OP_LEVEL_TO_TEMP: begin
            result = aux_chain[W] + root_chain[W];
         end
         mlsc_pkg::OP_UNSIGNED_TO_LVL, mlsc_pkg::OP_LVL_TO_UNSIGNED: begin
            result = aux_chain[W];
         end
         default: begin
            result = '0;
         end
      endcase
      range_error_in = ctrl_chain[W].err;
      converted_in   = ctrl_chain[W].err ? '0 : mlsc_pkg::FIELD_WIDTH'(result);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctrl_chain[W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         converted_ff   <= converted_in;
         range_error_ff <= range_error_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.converted   = converted_ff;
   assign rsp_chan.range_error = range_error_ff;

   a_error_gives_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && range_error_ff |-> converted_ff == '0)
      else $error("range error with non-zero result");

   a_stall_freezes_chain : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_vec))
      else $error("cell chain moved during a stall");

   a_last_cell_reaches_output : assert property (@(posedge clock) disable iff (reset)
      en && ctrl_chain[W].valid |=> rsp_valid_ff)
      else $error("word from last cell lost");

   a_error_only_on_temp : assert property (@(posedge clock) disable iff (reset)
      ctrl_chain[W].valid && ctrl_chain[W].err |->
         (ctrl_chain[W].opcode == mlsc_pkg::OP_TEMP_TO_LEVEL ||
          ctrl_chain[W].opcode == mlsc_pkg::OP_LEVEL_TO_TEMP))
      else $error("range error on a non-temperature opcode");

endmodule

// ===== design/mlsc_pre.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsc_pre
// Two-stage operand preparation: operand selection, then multiply and seed
// the digit recurrence of the cell chain.
// ----------------------------------------------------------------------------
module mlsc_pre #(
   parameter int W = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  mlsc_pkg::opcode_type    opcode,
   input  logic [W-1:0]            operand,
   input  logic [W-1:0]            lo,
   input  logic [W-1:0]            hi,
   output mlsc_pkg::cell_ctrl_type ctrl_out,
   output logic [W+1:0]            rem_out,
   output logic [2*W-1:0]          num_out,
   output logic [W-1:0]            root_out,
   output logic [W-1:0]            divisor_out,
   output logic [W-1:0]            aux_out
);

   localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
   localparam logic [W-1:0] HALF     = {1'b1, {(W-1){1'b0}}};

   mlsc_pkg::cell_ctrl_type a_ctrl_in, a_ctrl_ff, b_ctrl_ff;
   logic [W-1:0]   a_ma_in, a_ma_ff, a_mb_in, a_mb_ff, a_add_in, a_add_ff;
   logic [W-1:0]   a_div_in, a_div_ff, a_aux_in, a_aux_ff;
   logic [W-1:0]   clamped, diff, offset_lvl;
   logic [2*W-1:0] numer;
   logic [W+1:0]   b_rem_in, b_rem_ff;
   logic [2*W-1:0] b_num_in, b_num_ff;
   logic [W-1:0]   b_div_ff, b_aux_ff;

   always_comb begin
      diff       = hi - lo;
      offset_lvl = operand + HALF;
      if (operand < lo) begin
         clamped = lo;
      end else if (operand > hi) begin
         clamped = hi;
      end else begin
         clamped = operand;
      end
      a_ctrl_in.valid   = in_valid;
      a_ctrl_in.opcode  = opcode;
      a_ctrl_in.is_sqrt = 1'b0;
      a_ctrl_in.err     = 1'b0;
      a_ma_in  = '0;
      a_mb_in  = '0;
      a_add_in = '0;
      a_div_in = ALL_ONES;
      a_aux_in = '0;
      unique case (opcode)
         mlsc_pkg::OP_ACTUAL_TO_LINEAR: begin
            a_ma_in  = operand;
            a_mb_in  = operand;
            a_add_in = ALL_ONES - W'(1);
         end
         mlsc_pkg::OP_LINEAR_TO_ACTUAL: begin
            a_ma_in           = operand;
            a_mb_in           = ALL_ONES;
            a_ctrl_in.is_sqrt = 1'b1;
         end
         mlsc_pkg::OP_TEMP_TO_LEVEL: begin
            a_ma_in       = clamped - lo;
            a_mb_in       = ALL_ONES;
            a_div_in      = diff;
            a_ctrl_in.err = (hi <= lo);
         end
         mlsc_pkg::OP_LEVEL_TO_TEMP: begin
            a_ma_in       = offset_lvl;
            a_mb_in       = diff;
            a_aux_in      = lo;
            a_ctrl_in.err = (hi <= lo);
         end
         mlsc_pkg::OP_UNSIGNED_TO_LVL, mlsc_pkg::OP_LVL_TO_UNSIGNED: begin
            a_aux_in = offset_lvl;
         end
         default: begin
            a_aux_in = '0;
         end
      endcase
   end

   // The quotient and root always fit W bits, so the high half of a dividend
   // is already below the divisor and seeds the partial remainder directly.
   always_comb begin
      numer = a_ma_ff * a_mb_ff + {{W{1'b0}}, a_add_ff};
      if (a_ctrl_ff.is_sqrt) begin
         b_rem_in = '0;
         b_num_in = numer;
      end else begin
         b_rem_in = {2'b00, numer[2*W-1:W]};
         b_num_in = {numer[W-1:0], {W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff <= '0;
         b_ctrl_ff <= '0;
      end else if (en) begin
         a_ctrl_ff <= a_ctrl_in;
         b_ctrl_ff <= a_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ma_ff  <= a_ma_in;
         a_mb_ff  <= a_mb_in;
         a_add_ff <= a_add_in;
         a_div_ff <= a_div_in;
         a_aux_ff <= a_aux_in;
         b_rem_ff <= b_rem_in;
         b_num_ff <= b_num_in;
         b_div_ff <= a_div_ff;
         b_aux_ff <= a_aux_ff;
      end
   end

   assign ctrl_out    = b_ctrl_ff;
   assign rem_out     = b_rem_ff;
   assign num_out     = b_num_ff;
   assign root_out    = '0;
   assign divisor_out = b_div_ff;
   assign aux_out     = b_aux_ff;

endmodule

// ===== design/mlsc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsc_cell
// One restoring step of either long division or square root, registered.
// ----------------------------------------------------------------------------
module mlsc_cell #(
   parameter int W = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  mlsc_pkg::cell_ctrl_type ctrl_in,
   input  logic [W+1:0]            rem_in,
   input  logic [2*W-1:0]          num_in,
   input  logic [W-1:0]            root_in,
   input  logic [W-1:0]            divisor_in,
   input  logic [W-1:0]            aux_in,
   output mlsc_pkg::cell_ctrl_type ctrl_out,
   output logic [W+1:0]            rem_out,
   output logic [2*W-1:0]          num_out,
   output logic [W-1:0]            root_out,
   output logic [W-1:0]            divisor_out,
   output logic [W-1:0]            aux_out
);

   mlsc_pkg::cell_ctrl_type ctrl_ff;
   logic [W+1:0]   rem_shift, trial, rem_in_next, rem_ff;
   logic [2*W-1:0] num_in_next, num_ff;
   logic [W-1:0]   root_in_next, root_ff, div_ff, aux_ff;
   logic           take;

   // Square root brings down two bits against trial 4r+1; division one bit
   // against the divisor.
   always_comb begin
      if (ctrl_in.is_sqrt) begin
         rem_shift   = {rem_in[W-1:0], num_in[2*W-1:2*W-2]};
         trial       = {root_in, 2'b01};
         num_in_next = {num_in[2*W-3:0], 2'b00};
      end else begin
         rem_shift   = {1'b0, rem_in[W-1:0], num_in[2*W-1]};
         trial       = {2'b00, divisor_in};
         num_in_next = {num_in[2*W-2:0], 1'b0};
      end
      take         = (rem_shift >= trial);
      rem_in_next  = take ? rem_shift - trial : rem_shift;
      root_in_next = {root_in[W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in_next;
         num_ff  <= num_in_next;
         root_ff <= root_in_next;
         div_ff  <= divisor_in;
         aux_ff  <= aux_in;
      end
   end

   assign ctrl_out    = ctrl_ff;
   assign rem_out     = rem_ff;
   assign num_out     = num_ff;
   assign root_out    = root_ff;
   assign divisor_out = div_ff;
   assign aux_out     = aux_ff;

endmodule

// ===== sim/mlsc_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsc_tb_if
// Note: the channel interfaces live with the design sources; this file only
// collects the verification-side helper types used by the checker.
// ----------------------------------------------------------------------------
package mlsc_tb_pkg;

   import mlsc_pkg::*;

   // One expected response word.
   typedef struct packed {
      logic [FIELD_WIDTH-1:0] converted;
      logic                   range_error;
   } state_word_type;

endpackage

// ===== sim/mlsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsc_checker
// Watches the request, response and register channels, predicts every
// converted state and compares it with what the converter returns.
// ----------------------------------------------------------------------------
module mlsc_checker
   import mlsc_pkg::*;
   import mlsc_tb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   mlsc_req_if.sink      req_mon,
   mlsc_rsp_if.sink      rsp_mon,
   mlsc_csr_if.sink      csr_mon,
   output int            fail_count,
   output int            pending_count,
   output int            rsp_count
);

   localparam longint unsigned FULL  = 64'd65535;
   localparam longint unsigned HALF  = 64'd32768;

   logic [FIELD_WIDTH-1:0] range_lo;
   logic [FIELD_WIDTH-1:0] range_hi;
   state_word_type         pending_states[$];

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x)
            r = r | (64'd1 << b);
      end
      return r;
   endfunction

   function automatic state_word_type convert_state(opcode_type op,
                                                     logic [FIELD_WIDTH-1:0] operand);
      longint unsigned v, lo, hi, t, res;
      state_word_type  w;
      v = operand;
      lo = range_lo;
      hi = range_hi;
      res = 0;
      w.range_error = 1'b0;
      case (op)
         OP_ACTUAL_TO_LINEAR: res = (v * v + FULL - 1) / FULL;
         OP_LINEAR_TO_ACTUAL: res = int_sqrt(v * FULL);
         OP_TEMP_TO_LEVEL: begin
            if (hi <= lo) w.range_error = 1'b1;
            else begin
               t = (v < lo) ? lo : ((v > hi) ? hi : v);
               res = ((t - lo) * FULL / (hi - lo) - HALF) & FULL;
            end
         end
         OP_LEVEL_TO_TEMP: begin
            if (hi <= lo) w.range_error = 1'b1;
            else res = lo + ((v + HALF) & FULL) * (hi - lo) / FULL;
         end
         OP_UNSIGNED_TO_LVL, OP_LVL_TO_UNSIGNED: res = (v + HALF) & FULL;
         default: res = 0;
      endcase
      w.converted = res[FIELD_WIDTH-1:0];
      return w;
   endfunction

   assign pending_count = pending_states.size();

   always @(posedge clock) begin
      state_word_type want;
      if (reset) begin
         range_lo <= TEMP_MIN_RESET;
         range_hi <= TEMP_MAX_RESET;
         pending_states.delete();
         fail_count <= 0;
         rsp_count <= 0;
      end else begin
         // The response is checked before this edge's request is queued.
         if (rsp_mon.valid && rsp_mon.ready) begin
            rsp_count <= rsp_count + 1;
            if (pending_states.size() == 0) begin
               $error("unexpected word: converted %h", rsp_mon.converted);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_states.pop_front();
               if (want.converted !== rsp_mon.converted) begin
                  $error("converted: expected %h actual %h", want.converted,
                         rsp_mon.converted);
               end
               if (want.range_error !== rsp_mon.range_error) begin
                  $error("range_error: expected %b actual %b", want.range_error,
                         rsp_mon.range_error);
               end
               if (want !== {rsp_mon.converted, rsp_mon.range_error}) begin
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_states.push_back(convert_state(req_mon.opcode, req_mon.operand));
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_TEMP_MIN) range_lo <= csr_mon.data;
            else if (csr_mon.index == CSR_TEMP_MAX) range_hi <= csr_mon.data;
         end
      end
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the lighting state converter: directed corner
// words, then random conversions across several temperature ranges.
// ----------------------------------------------------------------------------
module tb;
   import mlsc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int  fail_count, pending_count, rsp_count;
   int  req_idle_pct = 0;
   int  rsp_idle_pct = 0;
   bit  hold_rsp     = 1'b0;
   int  sent         = 0;
   int  idle_cycles  = 0;

   mlsc_req_if req_chan ();
   mlsc_rsp_if rsp_chan ();
   mlsc_csr_if csr_chan ();

   mesh_light_state_converter_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   mlsc_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan.sink),
      .rsp_mon       (rsp_chan.sink),
      .csr_mon       (csr_chan.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .rsp_count     (rsp_count)
   );

   always #1 clock = ~clock;

   // The receiver decides its ready afresh at every falling edge, unless a
   // long hold-off is in force.
   always @(negedge clock) begin
      if (hold_rsp) rsp_chan.ready <= 1'b0;
      else          rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Watchdog: a long run of cycles with nothing moving ends the run.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready) || hold_rsp)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("status: fail");
         $finish;
      end
   end

   // Sends one word, idling beforehand at the current rate, and waits until
   // the converter takes it. Valid stays high afterwards so that words can
   // follow back to back; idling or draining drops it.
   task automatic send_word(opcode_type op, logic [FIELD_WIDTH-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.opcode  <= op;
      req_chan.operand <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   // Waits for every expected word, then for the pipeline to run dry.
   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (24) @(negedge clock);
   endtask

   task automatic write_range(logic [FIELD_WIDTH-1:0] lo, logic [FIELD_WIDTH-1:0] hi);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= CSR_TEMP_MIN;
      csr_chan.data  <= lo;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.index <= CSR_TEMP_MAX;
      csr_chan.data  <= hi;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Random words: mostly meaningful operands, with a few unused opcodes.
   task automatic send_random(int count);
      opcode_type op;
      logic [FIELD_WIDTH-1:0] v;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(19) == 0) ? opcode_type'($urandom_range(7, 6))
                                        : opcode_type'($urandom_range(5));
         case ($urandom_range(3))
            0:       v = $urandom_range(15);
            1:       v = 16'hFFFF - $urandom_range(15);
            default: v = $urandom;
         endcase
         send_word(op, v);
      end
   endtask

   initial begin
      logic [FIELD_WIDTH-1:0] corner[6];
      logic [FIELD_WIDTH-1:0] ranges[5][2];
      req_chan.valid   = 1'b0;
      req_chan.opcode  = OP_ACTUAL_TO_LINEAR;
      req_chan.operand = '0;
      rsp_chan.ready   = 1'b0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = CSR_TEMP_MIN;
      csr_chan.data    = '0;
      corner = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};
      // Range settings: wide, narrow, single-kelvin, empty and inverted.
      ranges = '{'{16'd0, 16'hFFFF}, '{16'd2700, 16'd6500}, '{16'd1000, 16'd1001},
                 '{16'd4000, 16'd4000}, '{16'hFFFF, 16'd0}};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at reset range: every opcode at the operand extremes,
      // temperatures below and above the range, and one unused opcode.
      for (int op = 0; op < 6; op++)
         for (int k = 0; k < 4; k++)
            send_word(opcode_type'(op), corner[k * 5 / 3]);
      send_word(opcode_type'(3'd6), 16'hFFFF);
      drain_pipeline();

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 82 : 0;
         rsp_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 16 : 0;
         for (int r = 0; r < 5; r++) begin
            write_range(ranges[r][0], ranges[r][1]);
            for (int k = 0; k < 6; k++) begin
               send_word(OP_TEMP_TO_LEVEL, corner[k]);
               send_word(OP_LEVEL_TO_TEMP, corner[k]);
            end
            send_random(110);
            drain_pipeline();
         end
      end

      // A long receiver hold-off fills the pipeline and backs up the input.
      fork
         begin
            hold_rsp = 1'b1;
            repeat (200) @(negedge clock);
            hold_rsp = 1'b0;
         end
         send_random(60);
      join
      drain_pipeline();
      write_range(TEMP_MIN_RESET, TEMP_MAX_RESET);
      send_random(20);
      drain_pipeline();

      $display("Sent %0d words over five temperature ranges and three idling mixes;", sent);
      $display("%0d converted words came back.", rsp_count);
      if (fail_count == 0) $display("status: pass");
      else                 $display("status: fail");
      $finish;
   end

endmodule
